FILE: rtl/dltq_pkg.sv
package dltq_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int ID_W       = 4;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam int VAL_W      = 31;
    localparam int SUM_W      = VAL_W + 1;
    localparam int IDLE_W     = 16;
    localparam int GT_W       = 32;

    localparam logic [IDLE_W-1:0] IDLE_WAIT_RESET = 16'd10000;

    localparam logic [1:0] OP_ARM    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_PENDING = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    typedef logic [ID_W-1:0]  t_id;
    typedef logic [VAL_W-1:0] t_val;

    typedef struct packed {
        t_id  rd_addr;
        logic dw_en;
        t_id  dw_addr;
        t_val dw_data;
        logic lw_en;
        t_id  lw_addr;
        t_id  lw_data;
        logic rw_en;
        t_id  rw_addr;
        t_val rw_data;
    } t_mem_req;

    typedef struct packed {
        t_val delta;
        t_id  link;
        t_val reload;
    } t_mem_rsp;

endpackage

FILE: rtl/dltq_store.sv
module dltq_store (
    input  logic              i_clk,
    input  dltq_pkg::t_mem_req i_req,
    output dltq_pkg::t_mem_rsp o_rsp
);
    import dltq_pkg::*;

    t_val delta_mem  [NUM_TIMERS];
    t_id  link_mem   [NUM_TIMERS];
    t_val reload_mem [NUM_TIMERS];

    t_val r_delta;
    t_id  r_link;
    t_val r_reload;

    always_ff @(posedge i_clk) begin
        if (i_req.dw_en) begin
            delta_mem[i_req.dw_addr] <= i_req.dw_data;
        end
        if (i_req.lw_en) begin
            link_mem[i_req.lw_addr] <= i_req.lw_data;
        end
        if (i_req.rw_en) begin
            reload_mem[i_req.rw_addr] <= i_req.rw_data;
        end
        r_delta  <= delta_mem[i_req.rd_addr];
        r_link   <= link_mem[i_req.rd_addr];
        r_reload <= reload_mem[i_req.rd_addr];
    end

    assign o_rsp = '{delta: r_delta, link: r_link, reload: r_reload};

endmodule

FILE: rtl/delta_list_timer_queue.sv
// delta-list timer queue
// input channel: i_in_valid / o_in_stall carries one request (op, timer_id,
//   reload, repeat_req); output channel: o_out_valid / i_out_stall carries one
//   result per request (status, fired, fired_id, global_time, next_expiry)
// config: i_cfg_we with i_cfg_data writes idle_wait at any idle moment
// sequence: read, rejected requests and non-expiring ticks go straight from
//   idle to the result register; arm passes S_INS_START only into an empty
//   queue, else S_INS_START, one S_WALK step per queued slot visited and
//   S_INS_WB; cancel steps S_RM_WALK through the slots up to the cancelled
//   one, then S_RM_SUCC when a successor remains; an expiring tick passes
//   S_FIRE_LINK, then S_FIRE_DELTA if slots remain, plus the arm walk when
//   the slot repeats; worst case is a repeating expiry that re-arms behind
//   every other queued slot, walking the synchronous link/delta memories one slot per cycle
// one request is in flight at a time; the next is taken in the cycle its
//   predecessor's result leaves the output register
// reset (synchronous, i_rst_n low) empties the queue, clears elapsed time and
//   countdown and restores idle_wait to 10000; memory contents are not cleared
// a stalled result holds; no new request is taken while it waits
module delta_list_timer_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_timer_id,
    input  logic [30:0] i_reload,
    input  logic        i_repeat_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_fired,
    output logic [3:0]  o_fired_id,
    output logic [31:0] o_global_time,
    output logic [30:0] o_next_expiry
);
    import dltq_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_INS_START  = 4'd1;
    localparam logic [3:0] S_WALK       = 4'd2;
    localparam logic [3:0] S_INS_WB     = 4'd3;
    localparam logic [3:0] S_RM_WALK    = 4'd4;
    localparam logic [3:0] S_RM_SUCC    = 4'd5;
    localparam logic [3:0] S_FIRE_LINK  = 4'd6;
    localparam logic [3:0] S_FIRE_DELTA = 4'd7;

    logic [3:0]            r_state, n_state;
    t_id                   r_head, n_head;
    logic                  r_nonempty, n_nonempty;
    t_val                  r_live, n_live;
    logic [GT_W-1:0]       r_elapsed, n_elapsed;
    logic [IDLE_W-1:0]     r_idle_wait;
    logic [NUM_TIMERS-1:0] r_pending, n_pending;
    logic [NUM_TIMERS-1:0] r_repeat, n_repeat;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    logic [1:0]            r_status, n_status;
    logic                  r_fired, n_fired;
    t_id                   r_fired_id, n_fired_id;

    // walk context
    t_id              r_id, n_id;
    t_val             r_t, n_t;
    t_id              r_cur, n_cur;
    t_id              r_prev, n_prev;
    logic [CNT_W-1:0] r_i, n_i;
    t_val             r_cum, n_cum;
    t_val             r_nd, n_nd;
    logic             r_wbd_en, n_wbd_en;
    logic             r_wbl_en, n_wbl_en;
    t_id              r_wbl_addr, n_wbl_addr;
    t_id              r_wbl_data, n_wbl_data;

    t_mem_req mem_req;
    t_mem_rsp mem_rsp;

    logic             accept;
    logic             done;
    t_val             walk_d;
    logic [SUM_W-1:0] walk_sum;
    t_val             walk_nd;
    logic [CNT_W-1:0] i_next;
    logic             rm_last;
    t_val             idle_ext;

    dltq_store u_store (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;
    assign idle_ext   = VAL_W'(r_idle_wait);

    assign walk_d   = (r_i == '0) ? r_live : mem_rsp.delta;
    assign walk_sum = SUM_W'(r_cum) + SUM_W'(walk_d);
    assign walk_nd  = r_t - r_cum;
    assign i_next   = r_i + CNT_W'(1);
    assign rm_last  = (i_next >= r_count);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_nonempty = r_nonempty;
        n_live     = r_live;
        n_elapsed  = r_elapsed;
        n_pending  = r_pending;
        n_repeat   = r_repeat;
        n_count    = r_count;
        n_status   = r_status;
        n_fired    = r_fired;
        n_fired_id = r_fired_id;
        n_id       = r_id;
        n_t        = r_t;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_i        = r_i;
        n_cum      = r_cum;
        n_nd       = r_nd;
        n_wbd_en   = r_wbd_en;
        n_wbl_en   = r_wbl_en;
        n_wbl_addr = r_wbl_addr;
        n_wbl_data = r_wbl_data;
        done       = 1'b0;
        mem_req    = '0;
        mem_req.rd_addr = r_head;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status   = ST_DONE;
                    n_fired    = 1'b0;
                    n_fired_id = '0;
                    n_id       = i_timer_id;
                    case (i_op)
                        OP_ARM: begin
                            if (r_pending[i_timer_id]) begin
                                n_status = ST_PENDING;
                                done     = 1'b1;
                            end else begin
                                mem_req.rw_en   = 1'b1;
                                mem_req.rw_addr = i_timer_id;
                                mem_req.rw_data = i_reload;
                                n_repeat[i_timer_id] = i_repeat_req;
                                n_t     = i_reload;
                                n_state = S_INS_START;
                            end
                        end
                        OP_CANCEL: begin
                            if (!r_pending[i_timer_id]) begin
                                n_status = ST_MISSING;
                                done     = 1'b1;
                            end else begin
                                n_cur   = r_head;
                                n_i     = '0;
                                n_state = S_RM_WALK;
                            end
                        end
                        OP_TICK: begin
                            n_elapsed = r_elapsed + GT_W'(1);
                            if (r_nonempty && r_live <= VAL_W'(1)) begin
                                // head expires: unlink it, fetch successor
                                n_fired    = 1'b1;
                                n_fired_id = r_head;
                                n_id       = r_head;
                                n_pending[r_head] = 1'b0;
                                n_count    = r_count - CNT_W'(1);
                                n_state    = S_FIRE_LINK;
                            end else begin
                                if (r_live <= VAL_W'(1)) begin
                                    n_live = r_nonempty ? r_live - VAL_W'(1) : idle_ext;
                                end else begin
                                    n_live = r_live - VAL_W'(1);
                                end
                                done = 1'b1;
                            end
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end

            S_INS_START: begin
                if (r_count == '0) begin
                    n_head     = r_id;
                    n_nonempty = 1'b1;
                    n_live     = r_t;
                    mem_req.dw_en   = 1'b1;
                    mem_req.dw_addr = r_id;
                    mem_req.dw_data = r_t;
                    n_pending[r_id] = 1'b1;
                    n_count    = r_count + CNT_W'(1);
                    done       = 1'b1;
                end else begin
                    n_cur   = r_head;
                    n_i     = '0;
                    n_cum   = '0;
                    n_state = S_WALK;
                end
            end

            S_WALK: begin
                if (SUM_W'(r_t) < walk_sum) begin
                    // new slot goes in front of r_cur
                    mem_req.dw_en   = 1'b1;
                    mem_req.dw_addr = r_cur;
                    mem_req.dw_data = walk_d - walk_nd;
                    mem_req.lw_en   = 1'b1;
                    mem_req.lw_addr = r_id;
                    mem_req.lw_data = r_cur;
                    if (r_i == '0) begin
                        n_head = r_id;
                        n_live = walk_nd;
                    end
                    n_nd       = walk_nd;
                    n_wbd_en   = 1'b1;
                    n_wbl_en   = (r_i != '0);
                    n_wbl_addr = r_prev;
                    n_wbl_data = r_id;
                    n_state    = S_INS_WB;
                end else begin
                    n_cum  = walk_sum[VAL_W-1:0];
                    n_prev = r_cur;
                    n_i    = i_next;
                    if (i_next < r_count) begin
                        n_cur = mem_rsp.link;
                        mem_req.rd_addr = mem_rsp.link;
                    end else begin
                        // append behind the tail
                        mem_req.dw_en   = 1'b1;
                        mem_req.dw_addr = r_id;
                        mem_req.dw_data = r_t - walk_sum[VAL_W-1:0];
                        mem_req.lw_en   = 1'b1;
                        mem_req.lw_addr = r_cur;
                        mem_req.lw_data = r_id;
                        n_wbd_en   = 1'b0;
                        n_wbl_en   = 1'b1;
                        n_wbl_addr = r_id;
                        n_wbl_data = '0;
                        n_state    = S_INS_WB;
                    end
                end
            end

            S_INS_WB: begin
                mem_req.dw_en   = r_wbd_en;
                mem_req.dw_addr = r_id;
                mem_req.dw_data = r_nd;
                mem_req.lw_en   = r_wbl_en;
                mem_req.lw_addr = r_wbl_addr;
                mem_req.lw_data = r_wbl_data;
                n_pending[r_id] = 1'b1;
                n_count = r_count + CNT_W'(1);
                done    = 1'b1;
            end

            S_RM_WALK: begin
                if (r_cur == r_id) begin
                    if (r_i == '0) begin
                        if (rm_last) begin
                            n_nonempty = 1'b0;
                            n_live     = idle_ext;
                            n_pending[r_id] = 1'b0;
                            n_count    = r_count - CNT_W'(1);
                            done       = 1'b1;
                        end else begin
                            n_head  = mem_rsp.link;
                            mem_req.rd_addr = mem_rsp.link;
                            n_state = S_RM_SUCC;
                        end
                    end else begin
                        mem_req.lw_en   = 1'b1;
                        mem_req.lw_addr = r_prev;
                        mem_req.lw_data = mem_rsp.link;
                        if (rm_last) begin
                            n_pending[r_id] = 1'b0;
                            n_count = r_count - CNT_W'(1);
                            done    = 1'b1;
                        end else begin
                            n_nd    = mem_rsp.delta;
                            n_cur   = mem_rsp.link;
                            mem_req.rd_addr = mem_rsp.link;
                            n_state = S_RM_SUCC;
                        end
                    end
                end else begin
                    n_prev = r_cur;
                    n_i    = i_next;
                    if (i_next < r_count) begin
                        n_cur = mem_rsp.link;
                        mem_req.rd_addr = mem_rsp.link;
                    end else begin
                        n_pending[r_id] = 1'b0;
                        done = 1'b1;
                    end
                end
            end

            S_RM_SUCC: begin
                // successor absorbs the removed delta
                if (r_i == '0) begin
                    n_live = r_live + mem_rsp.delta;
                end else begin
                    mem_req.dw_en   = 1'b1;
                    mem_req.dw_addr = r_cur;
                    mem_req.dw_data = mem_rsp.delta + r_nd;
                end
                n_pending[r_id] = 1'b0;
                n_count = r_count - CNT_W'(1);
                done    = 1'b1;
            end

            S_FIRE_LINK: begin
                n_t = mem_rsp.reload;
                if (r_count != '0) begin
                    n_head  = mem_rsp.link;
                    mem_req.rd_addr = mem_rsp.link;
                    n_state = S_FIRE_DELTA;
                end else begin
                    n_nonempty = 1'b0;
                    n_live     = idle_ext;
                    if (r_repeat[r_id]) begin
                        n_state = S_INS_START;
                    end else begin
                        done = 1'b1;
                    end
                end
            end

            S_FIRE_DELTA: begin
                n_live = mem_rsp.delta;
                if (r_repeat[r_id]) begin
                    n_state = S_INS_START;
                end else begin
                    done = 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (done) begin
            n_state = S_IDLE;
        end

        if (done) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_nonempty  <= 1'b0;
            r_live      <= '0;
            r_elapsed   <= '0;
            r_idle_wait <= IDLE_WAIT_RESET;
            r_pending   <= '0;
            r_repeat    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_nonempty  <= n_nonempty;
            r_live      <= n_live;
            r_elapsed   <= n_elapsed;
            r_pending   <= n_pending;
            r_repeat    <= n_repeat;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_idle_wait <= i_cfg_data;
            end
        end
    end

    // payload and walk context, no reset needed
    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_fired    <= n_fired;
        r_fired_id <= n_fired_id;
        r_id       <= n_id;
        r_t        <= n_t;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_i        <= n_i;
        r_cum      <= n_cum;
        r_nd       <= n_nd;
        r_wbd_en   <= n_wbd_en;
        r_wbl_en   <= n_wbl_en;
        r_wbl_addr <= n_wbl_addr;
        r_wbl_data <= n_wbl_data;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_fired       = r_fired;
    assign o_fired_id    = r_fired_id;
    assign o_global_time = r_elapsed;
    assign o_next_expiry = r_live;

endmodule
